>>> hw/rtl/rne_pkg.sv
// shared types, constants and symbol tables of the roman numeral encoder
package rne_pkg;

  localparam int NUM_W    = 17;
  localparam int SYM_W    = 16;
  localparam int PLACES   = 5;
  localparam int PLACE_W  = 3;
  localparam int DIGIT_W  = 4;
  localparam int POS_W    = 2;
  localparam int IDX_W    = 4;
  localparam logic [NUM_W-1:0] MAX_VALUE = 17'd99999;

  // symbol indexes: I V X L C D M 5000 10000 50000 100000
  localparam logic [IDX_W-1:0] SYM_I      = 4'd0;
  localparam logic [IDX_W-1:0] SYM_V      = 4'd1;
  localparam logic [IDX_W-1:0] SYM_X      = 4'd2;
  localparam logic [IDX_W-1:0] SYM_L      = 4'd3;
  localparam logic [IDX_W-1:0] SYM_C      = 4'd4;
  localparam logic [IDX_W-1:0] SYM_D      = 4'd5;
  localparam logic [IDX_W-1:0] SYM_M      = 4'd6;
  localparam logic [IDX_W-1:0] SYM_5K     = 4'd7;
  localparam logic [IDX_W-1:0] SYM_10K    = 4'd8;
  localparam logic [IDX_W-1:0] SYM_50K    = 4'd9;
  localparam logic [IDX_W-1:0] SYM_100K   = 4'd10;

  // picks within a place
  localparam logic [1:0] PICK_ONE  = 2'd0;
  localparam logic [1:0] PICK_FIVE = 2'd1;
  localparam logic [1:0] PICK_TEN  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_CONV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic conv;
    logic emit;
    logic mark_last;
    logic next_pos;
    logic next_place;
    logic special;
    logic special_oor;
  } cmd_t;

  typedef struct packed {
    logic oor;
    logic rem_zero;
    logic digit_zero;
    logic pos_last;
  } status_t;

  function automatic logic [NUM_W-1:0] place_value(input logic [PLACE_W-1:0] place);
    case (place)
      3'd0:    place_value = 17'd10000;
      3'd1:    place_value = 17'd1000;
      3'd2:    place_value = 17'd100;
      3'd3:    place_value = 17'd10;
      default: place_value = 17'd1;
    endcase
  endfunction

  // index of the "one" symbol of a place; five and ten follow it
  function automatic logic [IDX_W-1:0] place_base(input logic [PLACE_W-1:0] place);
    case (place)
      3'd0:    place_base = SYM_10K;
      3'd1:    place_base = SYM_M;
      3'd2:    place_base = SYM_C;
      3'd3:    place_base = SYM_X;
      default: place_base = SYM_I;
    endcase
  endfunction

  function automatic logic [POS_W:0] digit_len(input logic [DIGIT_W-1:0] d);
    case (d)
      4'd1, 4'd5:       digit_len = 3'd1;
      4'd2, 4'd4, 4'd6,
      4'd9:             digit_len = 3'd2;
      4'd3, 4'd7:       digit_len = 3'd3;
      4'd8:             digit_len = 3'd4;
      default:          digit_len = 3'd0;
    endcase
  endfunction

  function automatic logic [1:0] digit_pick(input logic [DIGIT_W-1:0] d,
                                            input logic [POS_W-1:0] pos);
    digit_pick = PICK_ONE;
    if (d == 4'd4 && pos == 2'd1) begin
      digit_pick = PICK_FIVE;
    end else if (d == 4'd9 && pos == 2'd1) begin
      digit_pick = PICK_TEN;
    end else if (d inside {[4'd5:4'd8]} && pos == 2'd0) begin
      digit_pick = PICK_FIVE;
    end
  endfunction

  function automatic logic [SYM_W-1:0] sym_code(input logic [IDX_W-1:0] idx,
                                                input logic upper);
    logic [SYM_W-1:0] code;
    logic             latin;
    latin = 1'b1;
    case (idx)
      SYM_I:    code = 16'h0049;
      SYM_V:    code = 16'h0056;
      SYM_X:    code = 16'h0058;
      SYM_L:    code = 16'h004C;
      SYM_C:    code = 16'h0043;
      SYM_D:    code = 16'h0044;
      SYM_M:    code = 16'h004D;
      SYM_5K:   begin code = 16'h2181; latin = 1'b0; end
      SYM_10K:  begin code = 16'h2182; latin = 1'b0; end
      SYM_50K:  begin code = 16'h2187; latin = 1'b0; end
      SYM_100K: begin code = 16'h2188; latin = 1'b0; end
      default:  begin code = '0; latin = 1'b0; end
    endcase
    // lower case latin letters sit 0x20 above the capitals
    if (latin && !upper) begin
      code = code | 16'h0020;
    end
    sym_code = code;
  endfunction

endpackage

>>> hw/rtl/roman_numeral_encoder.sv
// top level of the roman numeral encoder
// Takes one number while busy is low and start is high, and gives its Roman numeral one
// symbol at a time on the result ports, each for a single cycle marked by strobe, with
// last on the final one. After the load and a range check it walks the decimal places
// from the ten thousands down, extracting each digit (one compare bank against the place's
// nine multiples) and then emitting its symbols in turn; a zero digit, leading or inner,
// passes through the emit state without a symbol, and the run stops after the last
// non-zero digit. Zero and numbers above 99999 end at the range check and give one empty
// item, flagged out of range for the latter. Results are pushed out unconditionally and
// cannot be stalled.
module roman_numeral_encoder (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [rne_pkg::NUM_W-1:0] number,
  input  logic                      cfg_write,
  input  logic                      cfg_data,
  output logic [rne_pkg::SYM_W-1:0] symbol,
  output logic                      symbol_valid,
  output logic                      out_of_range,
  output logic                      last,
  output logic                      strobe
);

  rne_pkg::cmd_t    cmd;
  rne_pkg::status_t status;

  rne_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  rne_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .number       (number),
    .cmd          (cmd),
    .status       (status),
    .symbol       (symbol),
    .symbol_valid (symbol_valid),
    .out_of_range (out_of_range),
    .last         (last),
    .strobe       (strobe)
  );

endmodule

>>> hw/rtl/rne_ctrl.sv
// controller state machine of the roman numeral encoder
module rne_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  rne_pkg::status_t status,
  output rne_pkg::cmd_t    cmd,
  output logic             busy
);

  rne_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rne_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    case (state)
      rne_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = rne_pkg::ST_CHECK;
        end
      end
      rne_pkg::ST_CHECK: begin
        if (status.oor || status.rem_zero) begin
          cmd.special     = 1'b1;
          cmd.special_oor = status.oor;
          state_next      = rne_pkg::ST_IDLE;
        end else begin
          state_next = rne_pkg::ST_CONV;
        end
      end
      rne_pkg::ST_CONV: begin
        cmd.conv   = 1'b1;
        state_next = rne_pkg::ST_EMIT;
      end
      rne_pkg::ST_EMIT: begin
        if (status.digit_zero) begin
          cmd.next_place = 1'b1;
          state_next     = rne_pkg::ST_CONV;
        end else begin
          cmd.emit = 1'b1;
          if (status.pos_last) begin
            // nothing left below this place: this symbol ends the item
            if (status.rem_zero) begin
              cmd.mark_last = 1'b1;
              state_next    = rne_pkg::ST_IDLE;
            end else begin
              cmd.next_place = 1'b1;
              state_next     = rne_pkg::ST_CONV;
            end
          end else begin
            cmd.next_pos = 1'b1;
          end
        end
      end
      default: begin
        state_next = rne_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/rne_datapath.sv
// datapath of the roman numeral encoder: digit extraction and symbol output
module rne_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic                         cfg_data,
  input  logic [rne_pkg::NUM_W-1:0]    number,
  input  rne_pkg::cmd_t                cmd,
  output rne_pkg::status_t             status,
  output logic [rne_pkg::SYM_W-1:0]    symbol,
  output logic                         symbol_valid,
  output logic                         out_of_range,
  output logic                         last,
  output logic                         strobe
);

  logic                           upper_case;
  logic [rne_pkg::NUM_W-1:0]      rem;
  logic [rne_pkg::PLACE_W-1:0]    place;
  logic [rne_pkg::DIGIT_W-1:0]    digit;
  logic [rne_pkg::POS_W-1:0]      pos;

  logic [rne_pkg::NUM_W-1:0]      pv;
  logic [rne_pkg::DIGIT_W-1:0]    q;
  logic [rne_pkg::NUM_W-1:0]      q_mult;
  logic [rne_pkg::NUM_W-1:0]      rem_next;
  logic [rne_pkg::IDX_W-1:0]      sym_idx;
  logic [rne_pkg::POS_W:0]        len;

  // digit of the current place: count of multiples not above the remainder
  always_comb begin
    pv     = rne_pkg::place_value(place);
    q      = '0;
    q_mult = '0;
    for (int k = 1; k <= 9; k++) begin
      if (rem >= rne_pkg::NUM_W'(pv * k)) begin
        q      = rne_pkg::DIGIT_W'(k);
        q_mult = rne_pkg::NUM_W'(pv * k);
      end
    end
    rem_next = rem - q_mult;
  end

  always_comb begin
    len     = rne_pkg::digit_len(digit);
    sym_idx = rne_pkg::place_base(place)
              + rne_pkg::IDX_W'(rne_pkg::digit_pick(digit, pos));
  end

  assign status.oor        = rem > rne_pkg::MAX_VALUE;
  assign status.rem_zero   = rem == '0;
  assign status.digit_zero = digit == '0;
  assign status.pos_last   = ({1'b0, pos} + 3'd1) == len;

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe     <= 1'b0;
      upper_case <= 1'b0;
    end else begin
      strobe <= cmd.emit | cmd.special;
      if (cfg_write) begin
        upper_case <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem   <= number;
      place <= '0;
      pos   <= '0;
      digit <= '0;
    end
    if (cmd.conv) begin
      digit <= q;
      rem   <= rem_next;
    end
    if (cmd.next_pos) begin
      pos <= pos + 2'd1;
    end
    if (cmd.next_place) begin
      place <= place + 3'd1;
      pos   <= '0;
    end
    if (cmd.emit) begin
      symbol       <= rne_pkg::sym_code(sym_idx, upper_case);
      symbol_valid <= 1'b1;
      out_of_range <= 1'b0;
      last         <= cmd.mark_last;
    end else if (cmd.special) begin
      symbol       <= '0;
      symbol_valid <= 1'b0;
      out_of_range <= cmd.special_oor;
      last         <= 1'b1;
    end
  end

endmodule
